/* hdl/frame_rate_resampler_defines.svh */
// Assertion macros for the frame rate resampler.
// No dependencies; included by files that carry concurrent assertions.
`ifndef FRAME_RATE_RESAMPLER_DEFINES_SVH
`define FRAME_RATE_RESAMPLER_DEFINES_SVH

`ifndef SYNTHESIS
`define FRR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FRR_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FRR_ASSERT(lbl, clk, rst_n, prop, msg)
`define FRR_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

/* hdl/frr_pkg.sv */
// Shared types and constants for the frame rate resampler.
// No dependencies.
`default_nettype none

package frr_pkg;

  localparam int unsigned RATE_W   = 16;
  localparam int unsigned FRAMES_W = 32;
  localparam int unsigned ACC_W    = 32;
  localparam int unsigned MULT_W   = 10;
  localparam int unsigned PROD_W   = FRAMES_W + MULT_W;

  localparam logic [MULT_W-1:0] WINDOW_MS     = MULT_W'(1000);
  localparam logic [RATE_W-1:0] RATE_AT_RESET = RATE_W'(30);
  localparam logic [RATE_W-1:0] TARGET_AT_RESET = RATE_W'(25);

  typedef struct packed {
    logic busy;
    logic done;
  } frr_div_sts_t;

endpackage

`default_nettype wire

/* hdl/frame_rate_resampler.sv */
// A frame is taken in S_IDLE and runs through S_WIN, S_MUL, S_ADD, S_CMP and S_DONE; a frame that
// closes a one-second window also passes S_DIV, where the 42-step divider gives one quotient bit per cycle.
// No new frame is taken until S_DONE has loaded the result register, which waits while out_ready_i is low.
// A finished result waits in the output register while the next frame is taken.
// Reset: asynchronous active low; rate 30, credit 0, window empty, target 25.
`default_nettype none

`include "frame_rate_resampler_defines.svh"

module frame_rate_resampler #(
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [frr_pkg::RATE_W-1:0]   cfg_target_rate_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [TIME_BITS-1:0]         timestamp_ms_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         keep_frame_o,
  output logic [frr_pkg::RATE_W-1:0]   measured_rate_o
);
  import frr_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_WIN  = 7'b0000010,
    S_MUL  = 7'b0000100,
    S_DIV  = 7'b0001000,
    S_ADD  = 7'b0010000,
    S_CMP  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [RATE_W-1:0]    target_q, target_d;
  logic [RATE_W-1:0]    rate_q, rate_d;
  logic [ACC_W-1:0]     acc_q, acc_d;
  logic [FRAMES_W-1:0]  frames_q, frames_d;
  logic [TIME_BITS-1:0] start_q, start_d;
  logic [TIME_BITS-1:0] now_q, now_d;
  logic [TIME_BITS-1:0] elapsed_q, elapsed_d;
  logic                 keep_q, keep_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_keep_q, out_keep_d;
  logic [RATE_W-1:0]    out_rate_q, out_rate_d;

  logic [TIME_BITS-1:0] start_eff;
  logic                 div_start;
  logic [PROD_W-1:0]    div_num;
  logic [PROD_W-1:0]    div_quot;
  frr_div_sts_t         div_sts;
  logic [ACC_W-1:0]     rate_ext;
  logic [PROD_W-1:0]    frames_ext;

  assign start_eff  = (frames_q == '0) ? now_q : start_q;
  // frames * 1000 as 1024 - 16 - 8
  assign frames_ext = PROD_W'(frames_q);
  assign div_num    = (frames_ext << 10) - (frames_ext << 4) - (frames_ext << 3);
  assign rate_ext   = ACC_W'(rate_q);

  frr_div #(
    .DEN_W (TIME_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (elapsed_q),
    .quot_o  (div_quot),
    .sts_o   (div_sts)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d     = state_q;
    target_d    = target_q;
    rate_d      = rate_q;
    acc_d       = acc_q;
    frames_d    = frames_q;
    start_d     = start_q;
    now_d       = now_q;
    elapsed_d   = elapsed_q;
    keep_d      = keep_q;
    out_valid_d = out_valid_q;
    out_keep_d  = out_keep_q;
    out_rate_d  = out_rate_q;
    div_start   = 1'b0;

    if (cfg_valid_i) begin
      target_d = cfg_target_rate_i;
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          now_d   = timestamp_ms_i;
          state_d = S_WIN;
        end
      end
      S_WIN: begin
        start_d   = start_eff;
        frames_d  = frames_q + FRAMES_W'(1);
        elapsed_d = now_q - start_eff;
        state_d   = S_MUL;
      end
      S_MUL: begin
        if (elapsed_q > TIME_BITS'(WINDOW_MS)) begin
          div_start = 1'b1;
          start_d   = now_q;
          frames_d  = '0;
          state_d   = S_DIV;
        end else begin
          state_d = S_ADD;
        end
      end
      S_DIV: begin
        if (div_sts.done) begin
          rate_d  = (|div_quot[PROD_W-1:RATE_W]) ? '1 : div_quot[RATE_W-1:0];
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        acc_d   = acc_q + ACC_W'(target_q);
        state_d = S_CMP;
      end
      S_CMP: begin
        if (acc_q >= rate_ext) begin
          acc_d  = acc_q - rate_ext;
          keep_d = 1'b1;
        end else begin
          keep_d = 1'b0;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_keep_d  = keep_q;
          out_rate_d  = rate_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      target_q    <= TARGET_AT_RESET;
      rate_q      <= RATE_AT_RESET;
      acc_q       <= '0;
      frames_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      target_q    <= target_d;
      rate_q      <= rate_d;
      acc_q       <= acc_d;
      frames_q    <= frames_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q    <= start_d;
    now_q      <= now_d;
    elapsed_q  <= elapsed_d;
    keep_q     <= keep_d;
    out_keep_q <= out_keep_d;
    out_rate_q <= out_rate_d;
  end

  assign out_valid_o     = out_valid_q;
  assign keep_frame_o    = out_keep_q;
  assign measured_rate_o = out_rate_q;

  `FRR_ASSERT(a_idle_div_quiet, clk_i, rst_ni, (state_q == S_IDLE) |-> !div_sts.busy, "divider busy while idle")
  `FRR_ASSERT(a_done_in_div, clk_i, rst_ni, div_sts.done |-> (state_q == S_DIV), "divider done outside divide state")
  `FRR_ASSERT(a_drop_credit, clk_i, rst_ni, ((state_q == S_DONE) && !keep_q) |-> (acc_q < rate_ext), "dropped frame with credit at or above rate")

endmodule

`default_nettype wire

/* hdl/frr_div.sv */
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on frr_pkg (PROD_W, frr_div_sts_t).
`default_nettype none

module frr_div #(
  parameter int unsigned DEN_W = 48
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [frr_pkg::PROD_W-1:0] num_i,
  input  logic [DEN_W-1:0]          den_i,
  output logic [frr_pkg::PROD_W-1:0] quot_o,
  output frr_pkg::frr_div_sts_t     sts_o
);
  import frr_pkg::*;

  localparam int unsigned CNT_W = $clog2(PROD_W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [PROD_W-1:0] nq_q, nq_d;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign trial = {rem_q, nq_q[PROD_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = ~diff[DEN_W];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    nq_d   = nq_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      den_d  = den_i;
      nq_d   = num_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      nq_d  = {nq_q[PROD_W-2:0], ge};
      if (cnt_q == CNT_W'(PROD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    nq_q  <= nq_d;
  end

  assign quot_o     = nq_q;
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

endmodule

`default_nettype wire

/* test/frame_rate_resampler_tb.sv */
// Self-checking testbench for frame_rate_resampler: frame timestamps in, keep/drop verdicts out.
// A scoreboard class predicts rate measurement and credit decisions. Depends on frr_pkg.
`timescale 1ns / 1ps

module frame_rate_resampler_tb;

  localparam int unsigned TIME_W      = 48;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned BURST_LEN   = 30;

  localparam logic [TIME_W-1:0] TS_MAX = {TIME_W{1'b1}};

  typedef struct packed {
    logic                       keep;
    logic [frr_pkg::RATE_W-1:0] rate;
  } frame_verdict_t;

  class rate_scoreboard;
    logic [frr_pkg::RATE_W-1:0]   target;
    logic [frr_pkg::RATE_W-1:0]   rate;
    logic [frr_pkg::ACC_W-1:0]    credit;
    logic [frr_pkg::FRAMES_W-1:0] frames;
    logic [TIME_W-1:0]            win_start;
    frame_verdict_t               verdicts[$];
    int                           errors;

    function new();
      target    = frr_pkg::TARGET_AT_RESET;
      rate      = frr_pkg::RATE_AT_RESET;
      credit    = '0;
      frames    = '0;
      win_start = '0;
      errors    = 0;
    endfunction

    function int pending();
      return verdicts.size();
    endfunction

    function void note_frame(logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] elapsed;
      logic [63:0]       quot;
      frame_verdict_t    v;
      if (frames == '0) win_start = now;
      frames  = frames + frr_pkg::FRAMES_W'(1);
      elapsed = now - win_start;
      if (elapsed > TIME_W'(frr_pkg::WINDOW_MS)) begin
        quot = (64'(frames) * 64'(frr_pkg::WINDOW_MS)) / 64'(elapsed);
        rate = (quot > 64'({frr_pkg::RATE_W{1'b1}})) ? {frr_pkg::RATE_W{1'b1}}
                                                      : quot[frr_pkg::RATE_W-1:0];
        win_start = now;
        frames    = '0;
      end
      credit = credit + frr_pkg::ACC_W'(target);
      v.keep = (credit >= frr_pkg::ACC_W'(rate));
      if (v.keep) credit = credit - frr_pkg::ACC_W'(rate);
      v.rate = rate;
      verdicts.push_back(v);
    endfunction

    function void check_result(logic keep, logic [frr_pkg::RATE_W-1:0] meas);
      frame_verdict_t v;
      if (verdicts.size() == 0) begin
        $error("unexpected result: keep_frame %0d measured_rate %0d", keep, meas);
        errors++;
        return;
      end
      v = verdicts.pop_front();
      if (keep !== v.keep) begin
        $error("keep_frame: expected %0d, actual %0d", v.keep, keep);
        errors++;
      end
      if (meas !== v.rate) begin
        $error("measured_rate: expected %0d, actual %0d", v.rate, meas);
        errors++;
      end
    endfunction
  endclass

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  logic [frr_pkg::RATE_W-1:0] cfg_target_rate_i;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic [TIME_W-1:0]          timestamp_ms_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic                       keep_frame_o;
  logic [frr_pkg::RATE_W-1:0] measured_rate_o;

  rate_scoreboard    sb = new();
  bit                idle_on;
  logic [TIME_W-1:0] last_ts;
  int unsigned       cycle_count;
  int unsigned       stall_left;

  frame_rate_resampler #(
    .TIME_BITS(TIME_W)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_target_rate_i(cfg_target_rate_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .timestamp_ms_i   (timestamp_ms_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .keep_frame_o     (keep_frame_o),
    .measured_rate_o  (measured_rate_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(keep_frame_o, measured_rate_o);
  end

  initial begin
    out_ready_i <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0) out_ready_i <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        stall_left = $urandom_range(1, 15);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_frame(input logic [TIME_W-1:0] ts);
    in_valid_i     <= 1'b1;
    timestamp_ms_i <= ts;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_frame(ts);
    last_ts = ts;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_target(input logic [frr_pkg::RATE_W-1:0] value);
    drain_results();
    cfg_valid_i       <= 1'b1;
    cfg_target_rate_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.target = value;
  endtask

  // Steady streams with jitter, plus occasional backward, random and long jumps.
  task automatic run_stream(input int unsigned count);
    logic [TIME_W-1:0] ts;
    int unsigned       period;
    ts = last_ts;
    case ($urandom_range(0, 7))
      0, 1: ts = TIME_W'({$urandom, $urandom});
      2:    ts = TS_MAX - TIME_W'($urandom_range(0, 3000));
      default: ;
    endcase
    period = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 10) : $urandom_range(10, 250);
    repeat (count) begin
      case ($urandom_range(0, 24))
        0: ts = ts - TIME_W'($urandom_range(1, 100000));
        1: ts = TIME_W'({$urandom, $urandom});
        2: ;
        3: ts = ts + TIME_W'($urandom_range(1001, 20000));
        default: ts = ts + TIME_W'(period - period / 8 + $urandom_range(0, period / 4));
      endcase
      send_frame(ts);
    end
  endtask

  initial begin
    logic [TIME_W-1:0] base;
    rst_ni            <= 1'b0;
    cfg_valid_i       <= 1'b0;
    cfg_target_rate_i <= '0;
    in_valid_i        <= 1'b0;
    timestamp_ms_i    <= '0;
    idle_on = 1'b0;
    last_ts = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // one window closing just past a second
    send_frame(48'd0);
    send_frame(48'd200);
    send_frame(48'd400);
    send_frame(48'd600);
    send_frame(48'd800);
    send_frame(48'd1000);
    send_frame(48'd1001);
    // time going backwards, then rate zero
    send_frame(48'd2000);
    send_frame(48'd10);
    send_frame(48'd20);
    send_frame(48'd30);
    // all-ones timestamp and wrap of elapsed time
    send_frame(TS_MAX);
    send_frame(TS_MAX);
    send_frame(48'd1000);
    write_target('0);
    send_frame(48'd1500);
    send_frame(48'd1600);
    send_frame(48'd1700);
    write_target({frr_pkg::RATE_W{1'b1}});
    send_frame(48'd1800);
    send_frame(48'd1900);

    // dense window of equal timestamps with a max target and a small rate
    base = last_ts + 48'd10;
    send_frame(base);
    send_frame(base + 48'd1001);
    repeat (BURST_LEN) send_frame(base + 48'd2000);
    send_frame(base + 48'd3001);
    send_frame(base + 48'd3040);
    write_target(frr_pkg::TARGET_AT_RESET);

    for (int phase = 0; phase < 11; phase++) begin
      idle_on = (phase < 9) && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) < 7) begin
        case ($urandom_range(0, 5))
          0: write_target('0);
          1: write_target({frr_pkg::RATE_W{1'b1}});
          2: write_target(frr_pkg::RATE_W'($urandom_range(1, 10)));
          5: write_target(frr_pkg::RATE_W'($urandom_range(0, 65535)));
          default: write_target(frr_pkg::RATE_W'($urandom_range(1, 60)));
        endcase
      end else begin
        drain_results();
      end
      run_stream(100);
    end
    idle_on = 1'b0;

    drain_results();
    repeat (60) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
